>>> hw/rtl/dscl_pkg.sv
`default_nettype none
package dscl_pkg;

	localparam int ADDR_W          = 32;
	localparam int TAG_W           = 32;
	localparam int MAX_SETS        = 256;
	localparam int MAX_WAYS        = 8;
	localparam int MAX_DATA_BLOCKS = 4;
	localparam int MAX_ADDR_TAGS   = 4;

	localparam int SET_W    = $clog2(MAX_SETS);
	localparam int WAY_W    = $clog2(MAX_WAYS);
	localparam int WAYCNT_W = $clog2(MAX_WAYS + 1);
	localparam int BLK_W    = $clog2(MAX_DATA_BLOCKS);
	localparam int TSEL_W   = $clog2(MAX_ADDR_TAGS);
	localparam int SECTORS  = MAX_SETS * MAX_WAYS;
	localparam int SEC_W    = $clog2(SECTORS);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_BYTES_LOG2 = 3'd0,
		REG_SETS_LOG2        = 3'd1,
		REG_WAYS_IN_USE      = 3'd2,
		REG_DATA_BLOCKS_LOG2 = 3'd3,
		REG_ADDR_TAGS_LOG2   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_HIT        = 2'd0,
		ACT_WRITE_BACK = 2'd1,
		ACT_FETCH      = 2'd2
	} action_t;

	// per-block state inside a sector
	typedef struct packed {
		logic              valid;
		logic              dirty;
		logic [TSEL_W-1:0] sel;
	} blk_t;

	// one row of the sector metadata memory
	typedef struct packed {
		logic [31:0]                    stamp;
		logic [MAX_ADDR_TAGS-1:0]       tag_valid;
		blk_t [MAX_DATA_BLOCKS-1:0]     blk;
	} meta_t;

	typedef logic [MAX_ADDR_TAGS-1:0][TAG_W-1:0] tag_row_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_DECIDE,
		ST_LDV,
		ST_BLK,
		ST_INST
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic rd_way;
		logic ev_way;
		logic rd_vic;
		logic ld_vic;
		logic blk_step;
		logic install;
		logic emit_hit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic way_zero;
		logic hit;
		logic blk_last;
		logic blk_wb;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/dscl_ifs.sv
`default_nettype none
// access channel
interface dscl_acc_if;
	logic                      valid;
	logic                      ready;
	logic [dscl_pkg::ADDR_W-1:0] access_address;
	logic                      mode;
	modport source (output valid, access_address, mode, input ready);
	modport sink (input valid, access_address, mode, output ready);
endinterface

// result channel
interface dscl_res_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic [dscl_pkg::ADDR_W-1:0] next_address;
	logic                      last;
	modport source (output valid, action, next_address, last, input ready);
	modport sink (input valid, action, next_address, last, output ready);
endinterface

// configuration write channel
interface dscl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dscl_pkg::CFG_IDX_W-1:0]  index;
	logic [dscl_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/decoupled_sector_cache_lookup.sv
`default_nettype none
// Decoupled sectored cache lookup, one level, write-back and write-allocate.
// acc: one item per access (access_address, mode 0 read / 1 write).
// res: result items (action, next_address, last); a hit gives one hit item,
//   a miss gives one write-back per dirty evicted block, then the fetch.
// cfg: register writes (index, data), always ready; write only while idle.
// Walk: the ways are walked one at a time through the metadata and tag
//   memories, each way being read, then evaluated. acc is ready again the
//   cycle after the last item is loaded.
// Reset: a clearing pass sweeps the 2048 sector rows of metadata, one per
//   cycle; acc is not ready during the pass.
// Stall: a stalled receiver holds the output register; the block waits
//   before loading the next item and loses nothing.
module decoupled_sector_cache_lookup (
	input wire logic clk,
	input wire logic arst_n,
	dscl_acc_if.sink   acc,
	dscl_res_if.source res,
	dscl_cfg_if.sink   cfg
);
	import dscl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	dscl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc.valid),
		.acc_ready (acc.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dscl_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.acc_address      (acc.access_address),
		.acc_mode         (acc.mode),
		.cfg_valid        (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.res_valid        (res.valid),
		.res_ready        (res.ready),
		.res_action       (res.action),
		.res_next_address (res.next_address),
		.res_last         (res.last)
	);
endmodule
`default_nettype wire

>>> hw/rtl/dscl_ram.sv
`default_nettype none
module dscl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/dscl_ctrl.sv
`default_nettype none
module dscl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            acc_valid,
	output logic                 acc_ready,
	output dscl_pkg::cmd_t       cmd,
	input  wire dscl_pkg::sts_t  sts
);
	import dscl_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequence clear, way walk, then hit emit or victim read, block sweep, install
	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		acc_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				acc_ready = 1'b1;
				if (acc_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd_way = 1'b1;
				state_d    = ST_EV;
			end
			ST_EV: begin
				cmd.ev_way = 1'b1;
				state_d    = sts.way_zero ? ST_DECIDE : ST_RD;
			end
			ST_DECIDE: begin
				if (sts.hit) begin
					if (sts.out_free) begin
						cmd.emit_hit = 1'b1;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.rd_vic = 1'b1;
					state_d    = ST_LDV;
				end
			end
			ST_LDV: begin
				cmd.ld_vic = 1'b1;
				state_d    = ST_BLK;
			end
			ST_BLK: begin
				if (!sts.blk_wb || sts.out_free) begin
					cmd.blk_step = 1'b1;
					if (sts.blk_last) state_d = ST_INST;
				end
			end
			ST_INST: begin
				if (sts.out_free) begin
					cmd.install = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end
endmodule
`default_nettype wire

>>> hw/rtl/dscl_dp.sv
`default_nettype none
module dscl_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire dscl_pkg::cmd_t                  cmd,
	output dscl_pkg::sts_t                       sts,
	input  wire logic [dscl_pkg::ADDR_W-1:0]     acc_address,
	input  wire logic                            acc_mode,
	input  wire logic                            cfg_valid,
	input  wire logic [dscl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dscl_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output logic [1:0]                           res_action,
	output logic [dscl_pkg::ADDR_W-1:0]          res_next_address,
	output logic                                 res_last
);
	import dscl_pkg::*;

	// configuration
	logic [2:0]          bb_q;
	logic [3:0]          sl_q;
	logic [WAYCNT_W-1:0] ways_q;
	logic [1:0]          dl_q;
	logic [1:0]          tl_q;

	logic [3:0]          sl_eff;
	logic [1:0]          dl_eff;
	logic [1:0]          tl_eff;
	logic [WAYCNT_W-1:0] ways_eff;
	logic [WAY_W-1:0]    way_init;
	logic [4:0]          sh_c1, sh_c2, sh_c3;
	logic [BLK_W-1:0]    nblk_m1;
	logic [SET_W-1:0]    set_mask;
	logic [TSEL_W-1:0]   tsel_mask;

	// access
	logic [ADDR_W-1:0] addr_q;
	logic              wr_q;
	logic [BLK_W-1:0]  c0_q;
	logic [SET_W-1:0]  c1_q;
	logic [TSEL_W-1:0] c2_q;
	logic [TAG_W-1:0]  c3_q;

	// walk
	logic [WAY_W-1:0] way_q, lru_q, ib_q, it_q;
	logic             hit_q, have_ib_q, have_it_q;
	logic [31:0]      lru_stamp_q;
	logic [31:0]      counter_q;

	// victim
	logic [SEC_W-1:0] vic_sec_q;
	meta_t            vic_meta_q;
	tag_row_t         vic_tags_q;
	logic [BLK_W-1:0] blk_q;
	logic [WAY_W-1:0] vic_way;

	logic [SEC_W-1:0] clr_q;

	logic              out_valid_q;
	action_t           out_action_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              out_last_q;

	// memories
	meta_t            meta_rd, meta_wd, meta_upd, meta_new;
	tag_row_t         tag_rd, tags_new;
	logic             meta_we, tag_we;
	logic [SEC_W-1:0] meta_wa, rd_addr;

	logic tmatch, hitw, out_free;
	blk_t bcur, bm;
	logic [TAG_W-1:0] tg;
	logic conflict, evict, blk_wb;
	logic [ADDR_W-1:0] wb_addr;

	// saturate configuration
	always_comb begin
		sl_eff   = (sl_q > 4'(SET_W)) ? 4'(SET_W) : sl_q;
		dl_eff   = (dl_q > 2'(BLK_W)) ? 2'(BLK_W) : dl_q;
		tl_eff   = (tl_q > 2'(TSEL_W)) ? 2'(TSEL_W) : tl_q;
		ways_eff = (ways_q == '0) ? WAYCNT_W'(1) :
			((ways_q > WAYCNT_W'(MAX_WAYS)) ? WAYCNT_W'(MAX_WAYS) : ways_q);
		way_init  = WAY_W'(ways_eff - WAYCNT_W'(1));
		sh_c1     = 5'(bb_q) + 5'(dl_eff);
		sh_c2     = sh_c1 + 5'(sl_eff);
		sh_c3     = sh_c2 + 5'(tl_eff);
		nblk_m1   = BLK_W'((3'd1 << dl_eff) - 3'd1);
		set_mask  = SET_W'((9'd1 << sl_eff) - 9'd1);
		tsel_mask = TSEL_W'((3'd1 << tl_eff) - 3'd1);
	end

	// evaluate the way just read
	always_comb begin
		bcur   = meta_rd.blk[c0_q];
		tmatch = meta_rd.tag_valid[c2_q] && (tag_rd[c2_q] == c3_q);
		hitw   = tmatch && bcur.valid && (bcur.sel == c2_q);
		meta_upd       = meta_rd;
		meta_upd.stamp = counter_q;
		if (wr_q) meta_upd.blk[c0_q].dirty = 1'b1;
	end

	// victim block under the sweep
	always_comb begin
		vic_way  = have_ib_q ? ib_q : (have_it_q ? it_q : lru_q);
		bm       = vic_meta_q.blk[blk_q];
		tg       = vic_tags_q[bm.sel];
		conflict = ((bm.sel == c2_q) && (tg != c3_q)) || (blk_q == c0_q);
		evict    = conflict && bm.valid;
		blk_wb   = evict && bm.dirty;
		wb_addr  = (tg << sh_c3) | (ADDR_W'(bm.sel) << sh_c2) |
			(ADDR_W'(c1_q) << sh_c1) | (ADDR_W'(blk_q) << bb_q);
	end

	// installed sector
	always_comb begin
		meta_new                  = vic_meta_q;
		meta_new.blk[c0_q].valid  = 1'b1;
		meta_new.blk[c0_q].dirty  = wr_q;
		meta_new.blk[c0_q].sel    = c2_q;
		meta_new.tag_valid[c2_q]  = 1'b1;
		meta_new.stamp            = counter_q;
		tags_new                  = vic_tags_q;
		tags_new[c2_q]            = c3_q;
	end

	// memory port selection
	always_comb begin
		rd_addr = cmd.rd_vic ? {c1_q, vic_way} : {c1_q, way_q};
		meta_we = 1'b0;
		meta_wa = {c1_q, way_q};
		meta_wd = meta_upd;
		tag_we  = cmd.install;
		if (cmd.clr_step) begin
			meta_we = 1'b1;
			meta_wa = clr_q;
			meta_wd = '0;
		end else if (cmd.install) begin
			meta_we = 1'b1;
			meta_wa = vic_sec_q;
			meta_wd = meta_new;
		end else if (cmd.ev_way && hitw) begin
			meta_we = 1'b1;
		end
	end

	dscl_ram #(.WIDTH($bits(meta_t)), .DEPTH(SECTORS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_wa),
		.wdata (meta_wd),
		.raddr (rd_addr),
		.rdata (meta_rd)
	);

	dscl_ram #(.WIDTH($bits(tag_row_t)), .DEPTH(SECTORS)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (vic_sec_q),
		.wdata (tags_new),
		.raddr (rd_addr),
		.rdata (tag_rd)
	);

	assign out_free = !out_valid_q || res_ready;

	// control registers: configuration, counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q        <= 3'd4;
			sl_q        <= 4'd6;
			ways_q      <= WAYCNT_W'(2);
			dl_q        <= 2'd0;
			tl_q        <= 2'd0;
			clr_q       <= '0;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_BLOCK_BYTES_LOG2: bb_q   <= cfg_data[2:0];
					REG_SETS_LOG2:        sl_q   <= cfg_data[3:0];
					REG_WAYS_IN_USE:      ways_q <= WAYCNT_W'(cfg_data);
					REG_DATA_BLOCKS_LOG2: dl_q   <= cfg_data[1:0];
					REG_ADDR_TAGS_LOG2:   tl_q   <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) clr_q <= clr_q + SEC_W'(1);
			if (cmd.install || (cmd.ev_way && hitw)) counter_q <= counter_q + 32'd1;
			if (cmd.emit_hit || cmd.install || (cmd.blk_step && blk_wb)) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q      <= acc_address;
			wr_q        <= acc_mode;
			c0_q        <= BLK_W'(acc_address >> bb_q) & nblk_m1;
			c1_q        <= SET_W'(acc_address >> sh_c1) & set_mask;
			c2_q        <= TSEL_W'(acc_address >> sh_c2) & tsel_mask;
			c3_q        <= TAG_W'(acc_address >> sh_c3);
			way_q       <= way_init;
			lru_q       <= way_init;
			hit_q       <= 1'b0;
			have_ib_q   <= 1'b0;
			have_it_q   <= 1'b0;
		end
		if (cmd.ev_way) begin
			if (hitw) hit_q <= 1'b1;
			if ((way_q == way_init) || (meta_rd.stamp < lru_stamp_q)) begin
				lru_q       <= way_q;
				lru_stamp_q <= meta_rd.stamp;
			end
			if (tmatch && !bcur.valid) begin
				ib_q      <= way_q;
				have_ib_q <= 1'b1;
			end
			if (!meta_rd.tag_valid[c2_q] && !have_it_q) begin
				it_q      <= way_q;
				have_it_q <= 1'b1;
			end
			way_q <= way_q - WAY_W'(1);
		end
		if (cmd.rd_vic) vic_sec_q <= {c1_q, vic_way};
		if (cmd.ld_vic) begin
			vic_meta_q <= meta_rd;
			vic_tags_q <= tag_rd;
			blk_q      <= '0;
		end
		if (cmd.blk_step) begin
			if (evict) vic_meta_q.blk[blk_q] <= '0;
			blk_q <= blk_q + BLK_W'(1);
		end
		// load the output item
		if (cmd.emit_hit) begin
			out_action_q <= ACT_HIT;
			out_addr_q   <= addr_q;
			out_last_q   <= 1'b1;
		end else if (cmd.install) begin
			out_action_q <= ACT_FETCH;
			out_addr_q   <= addr_q;
			out_last_q   <= 1'b1;
		end else if (cmd.blk_step && blk_wb) begin
			out_action_q <= ACT_WRITE_BACK;
			out_addr_q   <= wb_addr;
			out_last_q   <= 1'b0;
		end
	end

	always_comb begin
		sts.clr_last = (clr_q == SEC_W'(SECTORS - 1));
		sts.way_zero = (way_q == '0);
		sts.hit      = hit_q;
		sts.blk_last = (blk_q == nblk_m1);
		sts.blk_wb   = blk_wb;
		sts.out_free = out_free;
	end

	assign res_valid        = out_valid_q;
	assign res_action       = out_action_q;
	assign res_next_address = out_addr_q;
	assign res_last         = out_last_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_hit || cmd.install || (cmd.blk_step && blk_wb)) |-> out_free)
		else $error("item loaded while output holds one");
	a_counter_inst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.install |=> (counter_q == $past(counter_q) + 32'd1))
		else $error("stamp counter missed an install");
	a_wb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_action_q == ACT_WRITE_BACK)) |-> !out_last_q)
		else $error("write-back marked last");
	a_ldv_blk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_vic |=> (blk_q == '0))
		else $error("block sweep did not start at zero");
endmodule
`default_nettype wire

>>> dv/dscl_test_pkg.sv
`timescale 1ns / 1ps
package dscl_test_pkg;
	import dscl_pkg::*;

	typedef struct {
		action_t     act;
		logic [31:0] addr;
		logic        last;
	} cache_resp_t;

	// Shadow of the cache level: tags, blocks, stamps and registers.
	class cache_scoreboard;
		logic [31:0] tag_val [2048][4];
		bit          tag_ok  [2048][4];
		bit          blk_ok  [2048][4];
		bit          blk_dirty [2048][4];
		bit [1:0]    blk_sel [2048][4];
		logic [31:0] stamp [2048];
		logic [31:0] counter;
		logic [2:0]  bb;
		logic [3:0]  sets_r;
		logic [3:0]  ways_r;
		logic [1:0]  dbl_r;
		logic [1:0]  atl_r;
		cache_resp_t pending[$];
		int          errors;

		function new();
			foreach (tag_ok[s, t]) begin
				tag_ok[s][t] = 0;
				tag_val[s][t] = '0;
			end
			foreach (blk_ok[s, b]) begin
				blk_ok[s][b] = 0;
				blk_dirty[s][b] = 0;
				blk_sel[s][b] = 0;
			end
			foreach (stamp[s]) stamp[s] = '0;
			counter = '0;
			bb = 4;
			sets_r = 6;
			ways_r = 2;
			dbl_r = 0;
			atl_r = 0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [3:0] val);
			case (idx)
				REG_BLOCK_BYTES_LOG2: bb = val[2:0];
				REG_SETS_LOG2:        sets_r = val;
				REG_WAYS_IN_USE:      ways_r = val;
				REG_DATA_BLOCKS_LOG2: dbl_r = val[1:0];
				REG_ADDR_TAGS_LOG2:   atl_r = val[1:0];
				default: ;
			endcase
		endfunction

		// Queue one predicted item at the tail.
		function void add_item(cache_resp_t r);
			pending.insert(pending.size(), r);
		endfunction

		// Predict the items of one access and update the shadow state.
		function void note_access(logic [31:0] addr, logic wr);
			int sl, dl, tl, ways, nblk, c0, c1, c2, lru, ib, it, vw, sec, sel;
			bit hit, have_ib, have_it, tmatch, conflict;
			logic [63:0] c, a;
			logic [31:0] c3;
			cache_resp_t r;
			sl = (sets_r > 8) ? 8 : int'(sets_r);
			dl = (dbl_r > 2) ? 2 : int'(dbl_r);
			tl = (atl_r > 2) ? 2 : int'(atl_r);
			ways = (ways_r == 0) ? 1 : ((ways_r > 8) ? 8 : int'(ways_r));
			nblk = 1 << dl;
			c = {32'd0, addr} >> bb;
			c0 = int'(c[31:0]) & (nblk - 1);
			c1 = int'(c[31:0] >> dl) & ((1 << sl) - 1);
			c2 = int'(c[31:0] >> (dl + sl)) & ((1 << tl) - 1);
			c3 = c[31:0] >> (dl + sl + tl);
			hit = 0;
			have_ib = 0;
			have_it = 0;
			ib = 0;
			it = 0;
			lru = ways - 1;
			for (int w = ways - 1; w >= 0; w--) begin
				sec = c1 * 8 + w;
				tmatch = tag_ok[sec][c2] && tag_val[sec][c2] == c3;
				if (tmatch && blk_ok[sec][c0] && blk_sel[sec][c0] == c2) begin
					hit = 1;
					stamp[sec] = counter;
					counter++;
					if (wr) blk_dirty[sec][c0] = 1;
				end
				if (stamp[sec] < stamp[c1 * 8 + lru]) lru = w;
				if (tmatch && !blk_ok[sec][c0]) begin
					ib = w;
					have_ib = 1;
				end
				if (!tag_ok[sec][c2] && !have_it) begin
					it = w;
					have_it = 1;
				end
			end
			if (hit) begin
				r.act = ACT_HIT;
				r.addr = addr;
				r.last = 1;
				add_item(r);
				return;
			end
			vw = have_ib ? ib : (have_it ? it : lru);
			sec = c1 * 8 + vw;
			for (int i = 0; i < nblk; i++) begin
				sel = int'(blk_sel[sec][i]);
				conflict = (sel == c2 && tag_val[sec][sel] != c3) || i == c0;
				if (conflict && blk_ok[sec][i]) begin
					if (blk_dirty[sec][i]) begin
						a = 64'(tag_val[sec][sel]);
						a = (a << tl) | 64'(sel);
						a = (a << sl) | 64'(c1);
						a = (a << dl) | 64'(i);
						a = a << bb;
						r.act = ACT_WRITE_BACK;
						r.addr = a[31:0];
						r.last = 0;
						add_item(r);
					end
					blk_sel[sec][i] = 0;
					blk_ok[sec][i] = 0;
					blk_dirty[sec][i] = 0;
				end
			end
			blk_ok[sec][c0] = 1;
			blk_dirty[sec][c0] = wr;
			blk_sel[sec][c0] = 2'(c2);
			tag_ok[sec][c2] = 1;
			tag_val[sec][c2] = c3;
			stamp[sec] = counter;
			counter++;
			r.act = ACT_FETCH;
			r.addr = addr;
			r.last = 1;
			add_item(r);
		endfunction

		// Compare one result item against the oldest prediction.
		function void check_result(logic [1:0] act, logic [31:0] addr, logic last);
			cache_resp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item act=%0d addr=%h last=%0d", act, addr, last);
				return;
			end
			e = pending.pop_front();
			if (act !== e.act || addr !== e.addr || last !== e.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp act=%0d addr=%h last=%0d got act=%0d addr=%h last=%0d",
						e.act, e.addr, e.last, act, addr, last);
			end
		endfunction
	endclass
endpackage

>>> dv/decoupled_sector_cache_lookup_test.sv
`timescale 1ns / 1ps
module decoupled_sector_cache_lookup_test;
	import dscl_pkg::*;
	import dscl_test_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	dscl_acc_if acc ();
	dscl_res_if res ();
	dscl_cfg_if cfg ();
	cache_scoreboard board;
	bit hold_off = 0;
	logic [31:0] addr_pool[$];

	decoupled_sector_cache_lookup dut (.clk(clk), .arst_n(arst_n), .acc(acc), .res(res),
		.cfg(cfg));

	always #6 clk = ~clk;

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	// Offer one access and hold it until accepted; valid stays high into the next one unless a gap is drawn.
	task automatic send_access(logic [31:0] a, logic wr);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
		if (gap > 0) begin
			acc.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		acc.valid <= 1;
		acc.access_address <= a;
		acc.mode <= wr;
		@(posedge clk);
		while (!acc.ready) @(posedge clk);
		board.note_access(a, wr);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [3:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		board.write_reg(idx, val);
	endtask

	// Drain outstanding items, then let the block settle before reconfiguring.
	task automatic wait_idle();
		acc.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_all(logic [3:0] b, logic [3:0] s, logic [3:0] w,
			logic [3:0] d, logic [3:0] t);
		wait_idle();
		write_reg(REG_BLOCK_BYTES_LOG2, b);
		write_reg(REG_SETS_LOG2, s);
		write_reg(REG_WAYS_IN_USE, w);
		write_reg(REG_DATA_BLOCKS_LOG2, d);
		write_reg(REG_ADDR_TAGS_LOG2, t);
		cfg.valid <= 0;
		addr_pool.delete();
	endtask

	// Mostly revisit a small pool so hits, sector sharing and evictions occur.
	task automatic random_phase(int n);
		logic [31:0] a;
		for (int i = 0; i < n; i++) begin
			if (addr_pool.size() < 6 || $urandom_range(0, 3) == 0) begin
				a = $urandom();
				addr_pool.insert(addr_pool.size(), a);
			end else begin
				a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
				if ($urandom_range(0, 2) == 0) a = a ^ (32'h1 << $urandom_range(0, 31));
			end
			send_access(a, 1'($urandom_range(0, 1)));
		end
	endtask

	// Receiver: random stalls, plus one long hold-off.
	always @(posedge clk) begin
		if (res.valid && res.ready)
			board.check_result(res.action, res.next_address, res.last);
	end

	initial begin
		int gap;
		res.ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				res.ready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			res.ready <= 1;
			@(posedge clk);
			if ($urandom_range(0, 2) == 0) begin
				gap = pick_gap();
				if (gap > 0) begin
					res.ready <= 0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin
		board = new();
		acc.valid = 0;
		acc.access_address = '0;
		acc.mode = 0;
		cfg.valid = 0;
		cfg.index = REG_BLOCK_BYTES_LOG2;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: default sizes, extremes, hit, dirty write-back.
		send_access(32'h0000_0000, 0);
		send_access(32'h0000_0000, 1);
		send_access(32'hFFFF_FFFF, 1);
		send_access(32'hFFFF_FFFF, 0);
		send_access(32'h0001_0000, 1);
		send_access(32'h0002_0000, 0);
		send_access(32'h0003_0000, 1);
		// Sectored: four blocks, four tags, one way: tag conflicts in a sector.
		set_all(2, 0, 1, 2, 2);
		send_access(32'h0000_0000, 1);
		send_access(32'h0000_0004, 1);
		send_access(32'h0000_0010, 1);
		send_access(32'h0000_0108, 1);
		send_access(32'h0000_0100, 0);
		send_access(32'h0000_000C, 1);
		send_access(32'h0000_1000, 0);
		// Out-of-range registers saturate; zero ways acts as one.
		set_all(7, 15, 0, 3, 3);
		send_access(32'h8000_0000, 1);
		send_access(32'h8000_0080, 1);
		send_access(32'h0000_0000, 0);
		set_all(0, 8, 15, 2, 0);
		for (int i = 0; i < 9; i++) send_access(32'h0000_0400 * i, 1);
		send_access(32'h0, 0);

		// Random phases over several settings.
		set_all(4, 6, 2, 0, 0);
		random_phase(15);
		set_all(2, 1, 4, 2, 1);
		hold_off = 1;
		random_phase(20);
		set_all(0, 0, 8, 2, 2);
		random_phase(20);
		set_all(3, 2, 3, 1, 2);
		random_phase(18);
		set_all(7, 8, 1, 0, 1);
		random_phase(10);

		acc.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end
endmodule
